@@ src/dft_pkg.sv @@
// package for the dshot frame transmitter: frame geometry, command codes,
// frame encoder and the slot timer step type. no dependencies.
package dft_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int RESET_SLOTS = 8;
    localparam int MOTOR_COUNT = 1;
    localparam int TOTAL_SLOTS = FRAME_BITS + RESET_SLOTS;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);
    localparam int PERIOD_W    = 16;
    localparam int THR_IN_W    = 16;
    localparam int THR_W       = 11;
    localparam int MOTOR_W     = 8;
    localparam int SLOT_OUT_W  = 5;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD   = PERIOD_W'(16);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16);
    localparam logic [THR_W-1:0]    THROTTLE_MAX = {THR_W{1'b1}};

    // register index within the apb window
    localparam logic REG_PERIOD = 1'b0;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_START = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                level;
        logic [PERIOD_W-1:0] tick_next;
        logic [SLOT_W-1:0]   slot_next;
    } slot_step_t;

    // throttle in bits 15..5, telemetry 0, xor of upper nibbles below
    function automatic logic [FRAME_BITS-1:0] encode_frame(input logic [THR_W-1:0] thr);
        logic [THR_W:0] word;
        logic [3:0]     crc;
        word = {thr, 1'b0};
        crc  = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, crc};
    endfunction

endpackage

@@ src/dft_slot_gen.sv @@
// slot timer step for the dshot transmitter: line level of one timer
// clock and the next tick and slot counts. depends on dft_pkg.
module dft_slot_gen
(
    input  logic [dft_pkg::PERIOD_W-1:0]   period_ticks,
    input  logic [dft_pkg::PERIOD_W-1:0]   tick_count,
    input  logic [dft_pkg::SLOT_W-1:0]     slot_count,
    input  logic [dft_pkg::FRAME_BITS-1:0] frame,
    output dft_pkg::slot_step_t            step
);

    logic [dft_pkg::PERIOD_W-1:0]  period_eff;
    logic [dft_pkg::PERIOD_W+1:0]  period_x3;
    logic [dft_pkg::PERIOD_W-1:0]  high_one;
    logic [dft_pkg::PERIOD_W-1:0]  high_zero;
    logic [dft_pkg::PERIOD_W-1:0]  high_len;
    logic [dft_pkg::BIT_IDX_W-1:0] bit_idx;
    logic                          data_slot;
    logic                          cur_bit;
    logic                          slot_end;
    logic                          last_slot;

    always_comb
    begin
        period_eff = (period_ticks < dft_pkg::MIN_PERIOD) ? dft_pkg::MIN_PERIOD : period_ticks;
        period_x3  = {2'b00, period_eff} + {1'b0, period_eff, 1'b0};
        high_one   = period_x3[dft_pkg::PERIOD_W+1:2];
        high_zero  = {1'b0, period_x3[dft_pkg::PERIOD_W+1:3]};

        data_slot  = slot_count < dft_pkg::SLOT_W'(dft_pkg::FRAME_BITS);
        // msb goes out first
        bit_idx    = dft_pkg::BIT_IDX_W'(dft_pkg::FRAME_BITS - 1)
                     - slot_count[dft_pkg::BIT_IDX_W-1:0];
        cur_bit    = frame[bit_idx];
        high_len   = cur_bit ? high_one : high_zero;
        step.level = data_slot && (tick_count < high_len);

        slot_end   = tick_count >= (period_eff - dft_pkg::PERIOD_W'(1));
        last_slot  = slot_count >= dft_pkg::SLOT_W'(dft_pkg::TOTAL_SLOTS - 1);

        if (slot_end)
        begin
            step.tick_next = '0;
            step.slot_next = last_slot ? '0 : slot_count + dft_pkg::SLOT_W'(1);
        end
        else
        begin
            step.tick_next = tick_count + dft_pkg::PERIOD_W'(1);
            step.slot_next = slot_count;
        end
    end

endmodule

@@ src/dshot_frame_transmitter.sv @@
// dshot frame transmitter top level: command decode, frame latching,
// result register and apb period register. depends on dft_pkg, dft_slot_gen.
//
// Takes one command item per clock and returns one result item for each:
// every item is handled in the cycle it is accepted and its result sits in a
// single output register, so it shows in the cycle after acceptance, and a new item is taken
// in every cycle while the output register is empty or being drained. A tick
// item is one timer clock of the waveform: a slot lasts period_ticks ticks
// (at least 16), a data bit is high for 3/8 of the slot for a 0 and 3/4 for a
// 1, msb first, then eight low reset slots, then the frame repeats. A throttle
// write is saturated to 2047 and encoded at once, but the new frame is only
// taken on the first tick of slot 0. Writes before the first start are
// dropped. period_ticks sits at byte address 0 and should only be written
// while no items are in flight.
module dshot_frame_transmitter
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic [dft_pkg::MOTOR_W-1:0]      motor_sel,
    input  logic [dft_pkg::THR_IN_W-1:0]     throttle,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             line_level,
    output logic                             running,
    output logic [dft_pkg::THR_W-1:0]        last_value,
    output logic [dft_pkg::SLOT_OUT_W-1:0]   slot_index,
    output logic                             frame_start,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dft_pkg::ADDR_W-1:0]       paddr,
    input  logic [dft_pkg::DATA_W-1:0]       pwdata,
    output logic [dft_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    logic [dft_pkg::PERIOD_W-1:0]   period_reg;
    logic [dft_pkg::FRAME_BITS-1:0] pending_reg,  pending_next;
    logic [dft_pkg::FRAME_BITS-1:0] active_reg,   active_next;
    logic [dft_pkg::PERIOD_W-1:0]   tick_reg,     tick_next;
    logic [dft_pkg::SLOT_W-1:0]     slot_reg,     slot_next;
    logic                           running_reg,  running_next;
    logic                           started_reg,  started_next;
    logic [dft_pkg::THR_W-1:0]      thr_reg,      thr_next;

    logic                           out_valid_reg;
    logic                           level_reg,    level_next;
    logic                           fstart_reg,   fstart_next;
    logic [dft_pkg::SLOT_W-1:0]     shown_reg,    shown_next;

    logic                           accept;
    logic                           cfg_write;
    logic                           new_frame;
    logic [dft_pkg::FRAME_BITS-1:0] frame_now;
    logic [dft_pkg::THR_W-1:0]      thr_clamped;
    dft_pkg::cmd_t                  cmd_code;
    dft_pkg::slot_step_t            step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == dft_pkg::REG_PERIOD)
                       ? {{(dft_pkg::DATA_W - dft_pkg::PERIOD_W){1'b0}}, period_reg} : '0;

    assign cmd_code    = dft_pkg::cmd_t'(cmd);
    assign new_frame   = (tick_reg == '0) && (slot_reg == '0);
    assign frame_now   = new_frame ? pending_reg : active_reg;
    assign thr_clamped = (|throttle[dft_pkg::THR_IN_W-1:dft_pkg::THR_W])
                         ? dft_pkg::THROTTLE_MAX : throttle[dft_pkg::THR_W-1:0];

    dft_slot_gen u_slot_gen
    (
        .period_ticks (period_reg),
        .tick_count   (tick_reg),
        .slot_count   (slot_reg),
        .frame        (frame_now),
        .step         (step)
    );

    always_comb
    begin
        pending_next = pending_reg;
        active_next  = active_reg;
        tick_next    = tick_reg;
        slot_next    = slot_reg;
        running_next = running_reg;
        started_next = started_reg;
        thr_next     = thr_reg;
        level_next   = 1'b0;
        fstart_next  = 1'b0;
        shown_next   = slot_reg;

        unique case (cmd_code)
            dft_pkg::CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (new_frame)
                    begin
                        active_next = pending_reg;
                        fstart_next = 1'b1;
                    end
                    level_next = step.level;
                    tick_next  = step.tick_next;
                    slot_next  = step.slot_next;
                end
            end
            dft_pkg::CMD_WRITE:
            begin
                if (started_reg && (motor_sel < dft_pkg::MOTOR_W'(dft_pkg::MOTOR_COUNT)))
                begin
                    thr_next     = thr_clamped;
                    pending_next = dft_pkg::encode_frame(thr_clamped);
                end
            end
            dft_pkg::CMD_STOP:
            begin
                running_next = 1'b0;
                thr_next     = '0;
                tick_next    = '0;
                slot_next    = '0;
                shown_next   = '0;
            end
            dft_pkg::CMD_START:
            begin
                thr_next     = '0;
                pending_next = dft_pkg::encode_frame('0);
                active_next  = dft_pkg::encode_frame('0);
                tick_next    = '0;
                slot_next    = '0;
                shown_next   = '0;
                running_next = 1'b1;
                started_next = 1'b1;
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= dft_pkg::PERIOD_RESET;
            pending_reg   <= dft_pkg::encode_frame('0);
            active_reg    <= dft_pkg::encode_frame('0);
            tick_reg      <= '0;
            slot_reg      <= '0;
            running_reg   <= 1'b0;
            started_reg   <= 1'b0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == dft_pkg::REG_PERIOD))
            begin
                period_reg <= pwdata[dft_pkg::PERIOD_W-1:0];
            end
            if (accept)
            begin
                pending_reg   <= pending_next;
                active_reg    <= active_next;
                tick_reg      <= tick_next;
                slot_reg      <= slot_next;
                running_reg   <= running_next;
                started_reg   <= started_next;
                thr_reg       <= thr_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg  <= level_next;
            fstart_reg <= fstart_next;
            shown_reg  <= shown_next;
        end
    end

    // running and last_value follow the state right after the item
    assign out_valid   = out_valid_reg;
    assign line_level  = level_reg;
    assign frame_start = fstart_reg;
    assign slot_index  = dft_pkg::SLOT_OUT_W'(shown_reg);
    assign running     = running_reg;
    assign last_value  = thr_reg;

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < dft_pkg::SLOT_W'(dft_pkg::TOTAL_SLOTS))
        else $error("slot counter out of range");

    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (tick_reg == '0) && (slot_reg == '0))
        else $error("timer moved while output stopped");

    a_fstart_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> (slot_index == '0) && running)
        else $error("frame start outside slot 0");

    a_low_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> !line_level)
        else $error("line high while stopped");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd_code == dft_pkg::CMD_START)
        |=> running_reg && started_reg && (thr_reg == '0))
        else $error("start did not reinitialize");
`endif

endmodule
